// ===== src/kps_pkg.sv =====
// Package for the 4x4 keypad scanner: phase type, key map and LED coding.
// No dependencies; used by matrix_keypad_scanner and its checker.
package kps_pkg;

	typedef enum logic [1:0] {
		PH_SETTLE   = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_RELEASE  = 2'd2,
		PH_DISPLAY  = 2'd3
	} phase_t;

	localparam int unsigned COL_W   = 4;
	localparam int unsigned ROW_W   = 2;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned LED_W   = 3;
	localparam int unsigned WAIT_W  = 10;
	localparam int unsigned SHORT_W = 8;
	localparam int unsigned IN_W    = 8;   // col_lines padded to a byte
	localparam int unsigned OUT_W   = 24;  // 19 field bits padded to three bytes

	localparam logic [1:0] CFG_SETTLE   = 2'd0;
	localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
	localparam logic [1:0] CFG_DISPLAY  = 2'd2;

	localparam logic [SHORT_W-1:0] SETTLE_RST   = 8'd2;
	localparam logic [SHORT_W-1:0] DEBOUNCE_RST = 8'd15;
	localparam logic [WAIT_W-1:0]  DISPLAY_RST  = 10'd300;

	localparam logic [COL_W-1:0] ALL_HIGH = 4'hF;

	// Key legend, row-major: 123A / 456B / 789C / *0#D
	function automatic logic [CHAR_W-1:0] key_char_of(input logic [3:0] idx);
		logic [CHAR_W-1:0] ch;
		case (idx)
			4'd0:    ch = 7'h31;
			4'd1:    ch = 7'h32;
			4'd2:    ch = 7'h33;
			4'd3:    ch = 7'h41;
			4'd4:    ch = 7'h34;
			4'd5:    ch = 7'h35;
			4'd6:    ch = 7'h36;
			4'd7:    ch = 7'h42;
			4'd8:    ch = 7'h37;
			4'd9:    ch = 7'h38;
			4'd10:   ch = 7'h39;
			4'd11:   ch = 7'h43;
			4'd12:   ch = 7'h2A;
			4'd13:   ch = 7'h30;
			4'd14:   ch = 7'h23;
			default: ch = 7'h44;
		endcase
		return ch;
	endfunction

	// bit0 green, bit1 red, bit2 yellow; column 3 lights all three
	function automatic logic [LED_W-1:0] led_of(input logic [ROW_W-1:0] col);
		logic [LED_W-1:0] p;
		case (col)
			2'd0:    p = 3'b001;
			2'd1:    p = 3'b010;
			2'd2:    p = 3'b100;
			default: p = 3'b111;
		endcase
		return p;
	endfunction

	// Lowest column that reads low; zero when none does
	function automatic logic [ROW_W-1:0] lowest_low(input logic [COL_W-1:0] c);
		logic [ROW_W-1:0] r;
		if (!c[0]) begin
			r = 2'd0;
		end else if (!c[1]) begin
			r = 2'd1;
		end else if (!c[2]) begin
			r = 2'd2;
		end else if (!c[3]) begin
			r = 2'd3;
		end else begin
			r = 2'd0;
		end
		return r;
	endfunction

endpackage

// ===== src/matrix_keypad_scanner.sv =====
// 4x4 matrix keypad scanner: one 1 ms tick beat in, one status beat out.
// Depends on kps_pkg for the phase type, key map and LED coding.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------------
//   s_*     | in  | s_tvalid/s_tready  | tick with sampled column lines
//   m_*     | out | m_tvalid/m_tready  | row drive, key event, index, char, LEDs
//   cfg_*   | in  | cfg_valid/cfg_ready| register index and write data
//
// A tick beat is registered in the input register on acceptance, evaluated against
// the scan state in the next cycle and its status beat moves into the output register;
// one beat can be taken every cycle while the output is not stalled.
// The scan state advances only when the evaluated beat moves into the output
// register; a stalled output holds the input register, which then drops s_tready.
// Reset (arst_n low) returns to row 0 in the settle phase with the default
// settle, debounce and display counts. Configuration is always ready.
module matrix_keypad_scanner (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [kps_pkg::IN_W-1:0]    s_tdata,   // [3:0] col_lines, [7:4] zero
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [kps_pkg::OUT_W-1:0]   m_tdata,   // [3:0] row_drive, [4] key_event,
	                                               // [8:5] key_index, [15:9] key_char,
	                                               // [16] led_green, [17] led_red,
	                                               // [18] led_yellow, [23:19] zero
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [kps_pkg::WAIT_W-1:0]  cfg_data
);
	import kps_pkg::*;

	// Configuration registers
	logic [SHORT_W-1:0] settle_q;
	logic [SHORT_W-1:0] debounce_q;
	logic [WAIT_W-1:0]  display_q;

	// Input register
	logic               valid_s1;
	logic [COL_W-1:0]   cols_s1;

	// Scan state
	phase_t             phase_q, phase_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [ROW_W-1:0]   held_q, held_d;
	logic [WAIT_W-1:0]  wait_q, wait_d;
	logic [LED_W-1:0]   led_q, led_d;

	// Result of the current beat
	logic               event_d;
	logic [3:0]         index_d;
	logic [COL_W-1:0]   row_drive_d;
	logic [LED_W-1:0]   leds_d;
	logic [WAIT_W:0]    wait_inc;

	// Output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic               advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign wait_inc  = {1'b0, wait_q} + {{WAIT_W{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q   <= SETTLE_RST;
			debounce_q <= DEBOUNCE_RST;
			display_q  <= DISPLAY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SETTLE:   settle_q   <= cfg_data[SHORT_W-1:0];
				CFG_DEBOUNCE: debounce_q <= cfg_data[SHORT_W-1:0];
				CFG_DISPLAY:  display_q  <= cfg_data;
				default:      ;  // unmapped index, drop the write
			endcase
		end
	end

	// Input register: take a tick whenever the slot is free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cols_s1 <= s_tdata[COL_W-1:0];
		end
	end

	// Scan state register, advanced once per evaluated tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SETTLE;
			row_q   <= '0;
			held_q  <= '0;
			wait_q  <= '0;
			led_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			row_q   <= row_d;
			held_q  <= held_d;
			wait_q  <= wait_d;
			led_q   <= led_d;
		end
	end

	// Next state and status for the tick held in the input register
	always_comb begin
		phase_d = phase_q;
		row_d   = row_q;
		held_d  = held_q;
		wait_d  = wait_q;
		led_d   = led_q;
		event_d = 1'b0;
		index_d = '0;
		case (phase_q)
			PH_SETTLE: begin
				if (wait_q < {{(WAIT_W-SHORT_W){1'b0}}, settle_q}) begin
					wait_d = wait_inc[WAIT_W-1:0];
				end else if (cols_s1 != ALL_HIGH) begin
					phase_d = PH_DEBOUNCE;
					wait_d  = '0;
				end else begin
					// nothing pressed on this row, move on
					row_d   = row_q + 2'd1;
					phase_d = PH_SETTLE;
					wait_d  = '0;
				end
			end
			PH_DEBOUNCE: begin
				if (wait_q < {{(WAIT_W-SHORT_W){1'b0}}, debounce_q}) begin
					wait_d = wait_inc[WAIT_W-1:0];
				end else if (cols_s1 != ALL_HIGH) begin
					held_d  = lowest_low(cols_s1);
					phase_d = PH_RELEASE;
					wait_d  = '0;
				end else begin
					// bounce: key gone on the confirming sample
					row_d   = row_q + 2'd1;
					phase_d = PH_SETTLE;
					wait_d  = '0;
				end
			end
			PH_RELEASE: begin
				// watch only the held column
				if (cols_s1[held_q]) begin
					event_d = 1'b1;
					index_d = {row_q, held_q};
					led_d   = led_of(held_q);
					phase_d = PH_DISPLAY;
					wait_d  = '0;
				end
			end
			default: begin
				wait_d = wait_inc[WAIT_W-1:0];
				if (wait_inc >= {1'b0, display_q}) begin
					led_d   = '0;
					row_d   = '0;
					phase_d = PH_SETTLE;
					wait_d  = '0;
				end
			end
		endcase

		if (phase_d == PH_DISPLAY) begin
			row_drive_d = ALL_HIGH;
			leds_d      = led_d;
		end else begin
			row_drive_d = ~(4'b0001 << row_d);
			leds_d      = '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {5'b0, leds_d[2], leds_d[1], leds_d[0],
				event_d ? key_char_of(index_d) : {CHAR_W{1'b0}},
				index_d, event_d, row_drive_d};
		end
	end

endmodule

// ===== src/kps_checker.sv =====
// Port-level checker for matrix_keypad_scanner, bound to the top level.
// Depends on kps_pkg for the output beat width.
module kps_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [kps_pkg::OUT_W-1:0]   m_tdata
);
	import kps_pkg::*;

	logic [3:0] row_drive;
	logic       key_event;
	logic [3:0] key_index;
	logic [6:0] key_char;
	logic [2:0] leds;

	assign row_drive = m_tdata[3:0];
	assign key_event = m_tdata[4];
	assign key_index = m_tdata[8:5];
	assign key_char  = m_tdata[15:9];
	assign leds      = m_tdata[18:16];

	// hold a stalled beat
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// a reported key always opens the display: rows released, LEDs lit
	a_event_display: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && key_event |-> row_drive == 4'hF && leds != 3'b000)
		else $error("key event without display");

	// index and char are zero outside an event
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !key_event |-> key_index == 4'd0 && key_char == 7'd0)
		else $error("key fields set without event");

	// while scanning exactly one row is low and the LEDs are off
	a_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && row_drive != 4'hF |-> $countones(row_drive) == 3 && leds == 3'b000)
		else $error("bad row drive while scanning");

endmodule

bind matrix_keypad_scanner kps_checker u_kps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
